[rtl/blsq_pkg.sv]
// ----------------------------------------------------------------------------
// blsq_pkg
// Shared widths and constants for the repeated-squaring base-2 logarithm.
// ----------------------------------------------------------------------------
package blsq_pkg;

    localparam int WORD_W  = 64;   // input value width
    localparam int HALF_W  = 32;   // squaring operand width
    localparam int POS_W   = 6;    // bit position within the input word
    localparam int HPOS_W  = 5;    // bit position within a half word
    localparam int SHIFT_W = 6;    // reduction shift, 1..32
    localparam int EXP_W   = 7;    // working exponent, never above 126
    localparam int FRAC_W  = 30;   // fraction output width
    localparam int CFG_W   = 5;    // frac_bits register width

    localparam logic [CFG_W-1:0] FRAC_BITS_RESET = 5'd16;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [HALF_W-1:0]  half_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [HPOS_W-1:0]  hpos_t;
    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [EXP_W-1:0]   exp_t;
    typedef logic [FRAC_W-1:0]  frac_t;
    typedef logic [CFG_W-1:0]   cfg_t;

endpackage

[rtl/blsq_in_if.sv]
// ----------------------------------------------------------------------------
// blsq_in_if
// Input channel: one unsigned 64-bit value per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface blsq_in_if;

    logic                 valid;
    logic                 ready;
    blsq_pkg::word_t      value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

[rtl/blsq_out_if.sv]
// ----------------------------------------------------------------------------
// blsq_out_if
// Result channel: integer part, fraction and zero flag per beat.
// ----------------------------------------------------------------------------
interface blsq_out_if;

    logic                 valid;
    logic                 ready;
    blsq_pkg::pos_t       int_part;
    blsq_pkg::frac_t      frac_part;
    logic                 zero_input;

    modport source (output valid, output int_part, output frac_part, output zero_input,
                    input ready);
    modport sink   (input valid, input int_part, input frac_part, input zero_input,
                    output ready);

endinterface

[rtl/blsq_msb.sv]
// ----------------------------------------------------------------------------
// blsq_msb
// Priority encoder: position of the highest set bit of a 32-bit word.
// ----------------------------------------------------------------------------
module blsq_msb
(
    input  blsq_pkg::half_t word,
    output blsq_pkg::hpos_t pos
);

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < blsq_pkg::HALF_W; i++)
        begin
            if (word[i])
            begin
                pos = blsq_pkg::hpos_t'(i);
            end
        end
    end

endmodule

[rtl/blsq_reduce.sv]
// ----------------------------------------------------------------------------
// blsq_reduce
// One reduction step: divide by 2^shift with ceiling, lower the exponent.
// ----------------------------------------------------------------------------
module blsq_reduce
(
    input  blsq_pkg::word_t  m,
    input  blsq_pkg::exp_t   n,
    input  blsq_pkg::shift_t shift,
    output blsq_pkg::word_t  m_out,
    output blsq_pkg::exp_t   n_out
);

    blsq_pkg::word_t low_mask;
    logic            sticky;
    blsq_pkg::exp_t  shift_ext;

    always_comb
    begin
        low_mask  = ~({blsq_pkg::WORD_W{1'b1}} << shift);
        sticky    = |(m & low_mask);
        m_out     = (m >> shift) + blsq_pkg::word_t'(sticky);
        shift_ext = blsq_pkg::exp_t'(shift);
        // clamp at zero when the shift exceeds the exponent
        n_out     = (n >= shift_ext) ? (n - shift_ext) : '0;
    end

endmodule

[rtl/binary_log_64bit_squaring.sv]
// ----------------------------------------------------------------------------
// binary_log_64bit_squaring: base-2 logarithm of a 64-bit value by squaring
// A zero input or a power of two skips the squaring rounds; otherwise the
//   fraction takes rounds = min(frac_bits, MAX_FRAC_BITS) squaring rounds,
//   each after the reduction steps it needs. One item at a time: the next
//   beat is taken once the result sits in the output register.
// Reset: rst_n clears the sequencer, output valid and sets frac_bits to 16.
// ----------------------------------------------------------------------------
module binary_log_64bit_squaring
#(
    parameter int MAX_FRAC_BITS = 30
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  blsq_pkg::cfg_t        cfg_wdata,
    blsq_in_if.sink               in_ch,
    blsq_out_if.source            out_ch
);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;   // wait for an input beat
    localparam logic [2:0] ST_HI    = 3'd1;   // find the top set bit
    localparam logic [2:0] ST_LO    = 3'd2;   // find the lowest set bit
    localparam logic [2:0] ST_STRIP = 3'd3;   // drop trailing zeros, set up rounds
    localparam logic [2:0] ST_RED   = 3'd4;   // reduce below 2^32 (repeats)
    localparam logic [2:0] ST_SQ    = 3'd5;   // square the working value
    localparam logic [2:0] ST_BIT   = 3'd6;   // emit one fraction bit
    localparam logic [2:0] ST_DONE  = 3'd7;   // hand result to output register

    localparam blsq_pkg::cfg_t MAX_ROUNDS = blsq_pkg::cfg_t'(MAX_FRAC_BITS);

    logic [2:0]        state_reg, state_next;
    blsq_pkg::cfg_t    frac_bits_reg;
    blsq_pkg::word_t   m_reg, m_next;
    blsq_pkg::exp_t    n_reg, n_next;
    blsq_pkg::pos_t    hi_reg, hi_next;
    blsq_pkg::pos_t    lo_reg, lo_next;
    blsq_pkg::cfg_t    rounds_reg, rounds_next;
    blsq_pkg::cfg_t    cnt_reg, cnt_next;
    blsq_pkg::frac_t   bits_reg, bits_next;
    logic              zero_reg, zero_next;

    logic              out_valid_reg;
    blsq_pkg::pos_t    out_int_reg;
    blsq_pkg::frac_t   out_frac_reg;
    logic              out_zero_reg;
    logic              out_load;

    // Shared priority encoder, steered by the sequencer
    blsq_pkg::half_t   enc_word;
    blsq_pkg::hpos_t   enc_pos;
    blsq_pkg::half_t   lo_word;
    logic              upper_nz;
    logic              lower_nz;

    // Reduction and bit test
    blsq_pkg::shift_t  red_shift;
    blsq_pkg::word_t   red_m;
    blsq_pkg::exp_t    red_n;
    logic [blsq_pkg::EXP_W:0] n_plus1;
    logic              bit_set;
    blsq_pkg::word_t   square;

    blsq_msb u_msb
    (
        .word (enc_word),
        .pos  (enc_pos)
    );

    blsq_reduce u_reduce
    (
        .m     (m_reg),
        .n     (n_reg),
        .shift (red_shift),
        .m_out (red_m),
        .n_out (red_n)
    );

    assign upper_nz  = |m_reg[blsq_pkg::WORD_W-1:blsq_pkg::HALF_W];
    assign lower_nz  = |m_reg[blsq_pkg::HALF_W-1:0];
    assign lo_word   = lower_nz ? m_reg[blsq_pkg::HALF_W-1:0]
                                : m_reg[blsq_pkg::WORD_W-1:blsq_pkg::HALF_W];
    // r = msb(m >> 32) + 1, in 1..32
    assign red_shift = blsq_pkg::shift_t'(enc_pos) + blsq_pkg::shift_t'(1);
    // Working value is below 2^32 here, so the square fits in 64 bits
    assign square    = blsq_pkg::word_t'(m_reg[blsq_pkg::HALF_W-1:0])
                     * blsq_pkg::word_t'(m_reg[blsq_pkg::HALF_W-1:0]);
    assign n_plus1   = {1'b0, n_reg} + 1'b1;
    // Fraction bit is one when m >= 2^(n+1), with n+1 still inside the word
    assign bit_set   = (n_plus1 <= (blsq_pkg::EXP_W+1)'(blsq_pkg::WORD_W - 1))
                     && ((m_reg >> n_plus1) != '0);

    always_comb
    begin
        // Steer the encoder: isolated low bit while searching for trailing zeros,
        // top half or bottom half while finding the top bit, upper half otherwise, as in reduction.
        case (state_reg)
            ST_LO:
            begin
                enc_word = lo_word & (~lo_word + blsq_pkg::half_t'(1));
            end
            ST_HI:
            begin
                enc_word = upper_nz ? m_reg[blsq_pkg::WORD_W-1:blsq_pkg::HALF_W]
                                    : m_reg[blsq_pkg::HALF_W-1:0];
            end
            default:
            begin
                enc_word = m_reg[blsq_pkg::WORD_W-1:blsq_pkg::HALF_W];
            end
        endcase
    end

    assign out_load     = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        n_next      = n_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        rounds_next = rounds_reg;
        cnt_next    = cnt_reg;
        bits_next   = bits_reg;
        zero_next   = zero_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    m_next    = in_ch.value;
                    bits_next = '0;
                    hi_next   = '0;
                    cnt_next  = '0;
                    zero_next = (in_ch.value == '0);
                    state_next = (in_ch.value == '0) ? ST_DONE : ST_HI;
                end
            end
            ST_HI:
            begin
                hi_next    = {upper_nz, enc_pos};
                state_next = ST_LO;
            end
            ST_LO:
            begin
                lo_next    = {~lower_nz, enc_pos};
                state_next = ST_STRIP;
            end
            ST_STRIP:
            begin
                // Drop trailing zeros; clamp the round count
                m_next      = m_reg >> lo_reg;
                n_next      = blsq_pkg::exp_t'(hi_reg - lo_reg);
                rounds_next = (frac_bits_reg > MAX_ROUNDS) ? MAX_ROUNDS : frac_bits_reg;
                if ((hi_reg == lo_reg) || (frac_bits_reg == '0))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                if (upper_nz)
                begin
                    m_next = red_m;
                    n_next = red_n;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                m_next     = square;
                n_next     = n_reg << 1;
                state_next = ST_BIT;
            end
            ST_BIT:
            begin
                bits_next = {bits_reg[blsq_pkg::FRAC_W-2:0], bit_set};
                if (bit_set)
                begin
                    n_next = n_plus1[blsq_pkg::EXP_W-1:0];
                end
                cnt_next = cnt_reg + blsq_pkg::cfg_t'(1);
                if ((cnt_reg + blsq_pkg::cfg_t'(1)) == rounds_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RED;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frac_bits_reg <= blsq_pkg::FRAC_BITS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                frac_bits_reg <= cfg_wdata;
            end
            // Hold the result beat until the sink takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        n_reg      <= n_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        rounds_reg <= rounds_next;
        cnt_reg    <= cnt_next;
        bits_reg   <= bits_next;
        zero_reg   <= zero_next;
        if (out_load)
        begin
            out_int_reg  <= hi_reg;
            out_frac_reg <= bits_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.int_part   = out_int_reg;
    assign out_ch.frac_part  = out_frac_reg;
    assign out_ch.zero_input = out_zero_reg;

endmodule

[sim/binary_log_64bit_squaring_checker.sv]
// ----------------------------------------------------------------------------
// binary_log_64bit_squaring_checker
// Watches the value and result channels and the frac_bits write port.
// Predicts each log2 result by repeated squaring and compares it in order.
// ----------------------------------------------------------------------------
module binary_log_64bit_squaring_checker
#(
    parameter int MAX_FRAC_BITS = 30
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  blsq_pkg::cfg_t cfg_wdata,
    blsq_in_if             in_mon,
    blsq_out_if            out_mon,
    output int             mismatch_count,
    output int             pending,
    output int             results_checked
);

    typedef struct packed {
        blsq_pkg::pos_t  int_part;
        blsq_pkg::frac_t frac_part;
        logic            zero_input;
    } log_result_t;

    log_result_t    expected_logs[$];
    blsq_pkg::cfg_t frac_bits;

    function automatic int unsigned highest_set(blsq_pkg::word_t x);
        int unsigned p;
        p = 0;
        for (int i = 1; i < blsq_pkg::WORD_W; i++)
        begin
            if (x[i])
                p = i;
        end
        return p;
    endfunction

    function automatic log_result_t predict_log2(blsq_pkg::word_t v,
                                                 blsq_pkg::cfg_t bits_cfg);
        log_result_t     res;
        blsq_pkg::word_t m;
        blsq_pkg::word_t mask;
        int unsigned     msb_pos;
        int unsigned     lsb_pos;
        int unsigned     n;
        int unsigned     r;
        int unsigned     rounds;
        res = '0;
        if (v == '0)
        begin
            res.zero_input = 1'b1;
            return res;
        end
        msb_pos = highest_set(v);
        lsb_pos = 0;
        while (!v[lsb_pos])
            lsb_pos++;
        res.int_part = blsq_pkg::pos_t'(msb_pos);
        if (msb_pos == lsb_pos)
            return res;
        // strip trailing zeros; m / 2^n stays in [1,2]
        m      = v >> lsb_pos;
        n      = msb_pos - lsb_pos;
        rounds = (bits_cfg > MAX_FRAC_BITS) ? MAX_FRAC_BITS : bits_cfg;
        for (int i = 0; i < rounds; i++)
        begin
            // shrink to 32 bits with ceiling rounding before squaring
            while (m[blsq_pkg::WORD_W-1:blsq_pkg::HALF_W] != '0)
            begin
                r    = highest_set(m >> blsq_pkg::HALF_W) + 1;
                mask = (blsq_pkg::word_t'(1) << r) - 1;
                m    = (m >> r) + (((m & mask) != '0) ? blsq_pkg::word_t'(1)
                                                      : blsq_pkg::word_t'(0));
                n    = (n >= r) ? n - r : 0;
            end
            m             = m * m;
            n             = n << 1;
            res.frac_part = res.frac_part << 1;
            if (n + 1 <= 63 && (m >> (n + 1)) != '0)
            begin
                res.frac_part[0] = 1'b1;
                n++;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, log_result_t got, log_result_t want);
        $display("MISMATCH %s: int_part %0d/%0d frac_part %h/%h zero_input %b/%b (got/exp)",
                 what, got.int_part, want.int_part, got.frac_part, want.frac_part,
                 got.zero_input, want.zero_input);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        log_result_t got;
        log_result_t want;
        if (!rst_n)
        begin
            frac_bits = blsq_pkg::FRAC_BITS_RESET;
            expected_logs.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                frac_bits = cfg_wdata;
            if (in_mon.valid && in_mon.ready)
                expected_logs.push_back(predict_log2(in_mon.value, frac_bits));
            if (out_mon.valid && out_mon.ready)
            begin
                got = '{out_mon.int_part, out_mon.frac_part, out_mon.zero_input};
                if (expected_logs.size() == 0)
                begin
                    report_mismatch("result beat with no value pending", got, '0);
                end
                else
                begin
                    want = expected_logs.pop_front();
                    results_checked++;
                    if (got != want)
                        report_mismatch("result fields", got, want);
                end
            end
            pending = expected_logs.size();
        end
    end

endmodule

[sim/binary_log_64bit_squaring_tb.sv]
// ----------------------------------------------------------------------------
// binary_log_64bit_squaring_tb
// Drives values into the log2 block across frac_bits settings and idling
// modes; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module binary_log_64bit_squaring_tb;

    localparam int MAX_FRAC_BITS   = 30;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 110;
    // Watchdog limit: many times the slowest item, stalls and sender gaps included.
    localparam int STALL_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 200;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
    typedef enum int {
        VAL_FULL, VAL_POW2, VAL_ZERO, VAL_NARROW, VAL_SHIFTED,
        VAL_ABOVE_POW2, VAL_BELOW_POW2, VAL_ONES
    } value_kind_e;

    // Extremes, zero, powers of two, trailing zeros and the 32-bit boundary
    // where the squaring operand first needs a reduction.
    localparam blsq_pkg::word_t DIRECTED_VALUES [20] = '{
        64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001,
        64'h0000_0000_0000_0002, 64'h0000_0000_0000_0003,
        64'h0000_0000_0000_0005, 64'h0000_0000_0000_0006,
        64'h0000_0000_0000_0007, 64'h0000_0000_0000_000A,
        64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFE,
        64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
        64'h0000_0001_0000_0001, 64'h0000_0001_8000_0000,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
        64'hC000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF
    };

    // Written frac_bits per phase: the limits, the saturating value 31 and a
    // few in between; the last phase picks one at random.
    localparam blsq_pkg::cfg_t PHASE_FRAC_BITS [NUM_PHASES-1] = '{
        5'd0, 5'd30, 5'd31, 5'd1, 5'd2, 5'd13, 5'd29
    };

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    blsq_pkg::cfg_t cfg_wdata;

    blsq_in_if  in_ch ();
    blsq_out_if out_ch ();

    int send_idle_pct;
    int recv_stall_pct;
    int values_sent;
    int zeros_sent;
    int pow2_sent;
    int idle_cycles;
    int mismatches;
    int pending;
    int results_checked;

    binary_log_64bit_squaring #(.MAX_FRAC_BITS(MAX_FRAC_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    binary_log_64bit_squaring_checker #(.MAX_FRAC_BITS(MAX_FRAC_BITS)) log_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .mismatch_count  (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: hold ready high unless a stall is drawn for this cycle.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no beat accepted in %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Pick a value class first so that zero, powers of two, narrow words and
    // long trailing-zero runs come up often; the full-width class toggles
    // every bit.
    function automatic blsq_pkg::word_t random_value();
        value_kind_e     kind;
        blsq_pkg::word_t full;
        int unsigned     k;
        kind = value_kind_e'($urandom_range(int'(VAL_ONES)));
        full = {$urandom, $urandom};
        k    = $urandom_range(blsq_pkg::WORD_W - 1);
        case (kind)
            VAL_POW2:       return blsq_pkg::word_t'(1) << k;
            VAL_ZERO:       return ($urandom_range(3) == 0) ? blsq_pkg::word_t'(0) : full;
            VAL_NARROW:     return full >> k;
            VAL_SHIFTED:    return (full | blsq_pkg::word_t'(1)) << k;
            VAL_ABOVE_POW2: return (blsq_pkg::word_t'(1) << k)
                                   + blsq_pkg::word_t'($urandom_range(7));
            VAL_BELOW_POW2: return (blsq_pkg::word_t'(1) << k)
                                   - blsq_pkg::word_t'($urandom_range(1, 7));
            VAL_ONES:       return ~blsq_pkg::word_t'(0) >> k;
            default:        return full;
        endcase
    endfunction

    // Present one value beat and wait until it is taken. Valid stays high
    // after the beat so back-to-back beats need no drop; drop it only for a gap.
    task automatic send_value(input blsq_pkg::word_t v);
        int gap;
        gap = 0;
        if (send_idle_pct != 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
                gap++;
            // now and then a long gap, to land on later phases of the rounds
            if ($urandom_range(3) == 0)
                gap += $urandom_range(60);
        end
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do
            @(posedge clk);
        while (!in_ch.ready);
        values_sent++;
        if (v == '0)
            zeros_sent++;
        else if ((v & (v - 1)) == '0)
            pow2_sent++;
    endtask

    // Drop valid in the step of the last beat, then wait for every result.
    task automatic end_phase();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Write frac_bits for one edge; only called with the block idle.
    task automatic write_frac_bits(input blsq_pkg::cfg_t bits);
        cfg_we    <= 1'b1;
        cfg_wdata <= bits;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_SEND:
            begin
                send_idle_pct  = 73;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 73;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 37;
                recv_stall_pct = 37;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        blsq_pkg::cfg_t bits;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.value     = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        values_sent     = 0;
        zeros_sent      = 0;
        pow2_sent       = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed values at the reset setting of frac_bits, no idling.
        foreach (DIRECTED_VALUES[i])
            send_value(DIRECTED_VALUES[i]);
        end_phase();

        // Random phases: advance frac_bits while idle, rotate the idling mode.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            bits = (p < NUM_PHASES - 1) ? PHASE_FRAC_BITS[p]
                                        : blsq_pkg::cfg_t'($urandom_range(31));
            write_frac_bits(bits);
            set_idle(idle_mode_e'(p % 4));
            repeat (ITEMS_PER_PHASE)
                send_value(random_value());
            end_phase();
        end

        set_idle(IDLE_NONE);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d values (%0d zero, %0d powers of two), %0d results checked,",
                 values_sent, zeros_sent, pow2_sent, results_checked);
        $display("frac_bits at reset value, 0, 30, 31 and others, under four idling modes");
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
rtl/blsq_pkg.sv
rtl/blsq_in_if.sv
rtl/blsq_out_if.sv
rtl/blsq_msb.sv
rtl/blsq_reduce.sv
rtl/binary_log_64bit_squaring.sv
sim/binary_log_64bit_squaring_checker.sv
sim/binary_log_64bit_squaring_tb.sv
